FILE: hdl/fkd_pkg.sv
`timescale 1ns / 1ps

package fkd_pkg;

    localparam int KEY_COUNT = 5;
    localparam int PIN_COUNT = 4;
    localparam int OK_KEY = 4;

    localparam int KEY_IDX_W = 3;
    localparam int PIN_W = 4;
    localparam int LEVEL_W = 12;
    localparam int TIME_W = 32;
    localparam int DEB_W = 16;
    localparam int THR_W = 12;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(50);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);
    localparam logic [KEY_COUNT-1:0] RAW_RESET = KEY_COUNT'(1) << OK_KEY;

    typedef enum logic {
        t_REG_DEBOUNCE = 1'b0,
        t_REG_THRESHOLD = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_ms;
        logic [THR_W-1:0] ok_threshold;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic [KEY_COUNT-1:0] mask;
        logic [KEY_COUNT-1:0] state;
    } t_evt;

endpackage

FILE: hdl/fkd_cfg.sv
`timescale 1ns / 1ps

module fkd_cfg import fkd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(paddr[2]);
    assign w_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms <= DEB_RESET;
            r_cfg.ok_threshold <= THR_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                t_REG_DEBOUNCE:  r_cfg.debounce_ms <= pwdata[DEB_W-1:0];
                t_REG_THRESHOLD: r_cfg.ok_threshold <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            t_REG_DEBOUNCE:  prdata = APB_DATA_W'(r_cfg.debounce_ms);
            t_REG_THRESHOLD: prdata = APB_DATA_W'(r_cfg.ok_threshold);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: hdl/fkd_core.sv
`timescale 1ns / 1ps

module fkd_core import fkd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [PIN_W-1:0]   i_pin_levels,
    input  logic [LEVEL_W-1:0] i_ok_level,
    input  logic [TIME_W-1:0]  i_now_ms,
    input  logic               i_emit_ready,
    output t_evt               o_evt
);

    logic                 r_in_vld;
    logic [PIN_W-1:0]     r_pins;
    logic [LEVEL_W-1:0]   r_level;
    logic [TIME_W-1:0]    r_now;

    logic [KEY_COUNT-1:0] r_raw;
    logic [KEY_COUNT-1:0] r_stable;
    logic [TIME_W-1:0]    r_chg [KEY_COUNT];

    logic [KEY_COUNT-1:0] w_sample;
    logic [KEY_COUNT-1:0] w_fire;
    logic [KEY_COUNT-1:0] n_stable;
    logic [TIME_W-1:0]    n_chg [KEY_COUNT];
    logic [TIME_W-1:0]    w_elapsed [KEY_COUNT];
    logic                 w_step;
    logic                 w_accept;

    assign w_step = r_in_vld && i_emit_ready;
    assign o_in_stall = r_in_vld && !i_emit_ready;
    assign w_accept = i_in_valid && !o_in_stall;

    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (k < PIN_COUNT) begin
                w_sample[k] = !r_pins[k % PIN_COUNT];
            end else if (k == OK_KEY) begin
                w_sample[k] = (r_level > i_cfg.ok_threshold);
            end else begin
                w_sample[k] = 1'b0;
            end
            n_chg[k] = (r_raw[k] != w_sample[k]) ? r_now : r_chg[k];
            w_elapsed[k] = r_now - n_chg[k];
            w_fire[k] = (n_chg[k] != '0) &&
                        (w_elapsed[k] > TIME_W'(i_cfg.debounce_ms)) &&
                        (r_stable[k] != w_sample[k]);
            n_stable[k] = w_fire[k] ? w_sample[k] : r_stable[k];
        end
    end

    assign o_evt.load = w_step && (|w_fire);
    assign o_evt.mask = w_fire;
    assign o_evt.state = n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_stable <= '0;
            r_raw <= RAW_RESET;
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_chg[k] <= '0;
            end
        end else begin
            r_in_vld <= w_accept || (r_in_vld && !w_step);
            if (w_step) begin
                r_raw <= w_sample;
                r_stable <= n_stable;
                for (int k = 0; k < KEY_COUNT; k++) begin
                    r_chg[k] <= n_chg[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pins <= i_pin_levels;
            r_level <= i_ok_level;
            r_now <= i_now_ms;
        end
    end

endmodule

FILE: hdl/fkd_emit.sv
`timescale 1ns / 1ps

module fkd_emit import fkd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_evt                 i_evt,
    output logic                 o_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [KEY_IDX_W-1:0] o_key_index,
    output logic                 o_pressed,
    output logic                 o_last
);

    logic [KEY_COUNT-1:0] r_mask;
    logic [KEY_COUNT-1:0] r_state;
    logic                 r_out_vld;
    logic [KEY_IDX_W-1:0] r_key;
    logic                 r_pressed;
    logic                 r_last;

    logic [KEY_COUNT-1:0] w_low;
    logic [KEY_COUNT-1:0] w_mask_after;
    logic [KEY_IDX_W-1:0] w_idx;
    logic                 w_found;
    logic                 w_out_free;
    logic                 w_pop;

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_pop = (|r_mask) && w_out_free;
    assign w_low = r_mask & (~r_mask + KEY_COUNT'(1));
    assign w_mask_after = w_pop ? (r_mask & ~w_low) : r_mask;
    assign o_ready = (w_mask_after == '0);

    always_comb begin
        w_idx = '0;
        w_found = 1'b0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (!w_found && r_mask[k]) begin
                w_idx = KEY_IDX_W'(k);
                w_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_evt.load) begin
                r_mask <= i_evt.mask;
            end else begin
                r_mask <= w_mask_after;
            end
            if (w_pop) begin
                r_out_vld <= 1'b1;
            end else if (w_out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.load) begin
            r_state <= i_evt.state;
        end
        if (w_pop) begin
            r_key <= w_idx;
            r_pressed <= r_state[w_idx];
            r_last <= (w_mask_after == '0);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_key_index = r_key;
    assign o_pressed = r_pressed;
    assign o_last = r_last;

`ifndef SYNTHESIS
    a_load_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.load |-> (w_mask_after == '0))
        else $error("An item was loaded while events were still pending.");

    a_load_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.load |-> (|i_evt.mask))
        else $error("An item with no events was loaded.");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_last) |-> (|r_mask))
        else $error("An event without the last flag has no successor.");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (32'(r_key) < 32'(KEY_COUNT)))
        else $error("Key index is out of range.");
`endif

endmodule

FILE: hdl/five_key_debouncer.sv
`timescale 1ns / 1ps

// Debouncer for four active-low pin keys and one analog key.
// The input channel takes one sample tick per item: pin levels, the analog
// level and the current millisecond time. The output channel gives one item
// per stable key change, in key order, with the last flag set on the final
// item caused by a tick. A tick that causes no change gives no output item.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The APB port sets the debounce time and the analog
// threshold, and should be written only while the block is idle.
// The first event of a tick passes the input register, the serializer mask
// and the output register. A tick with several events holds the serializer
// until all have left, since the single output register carries one event
// per cycle if not stalled; ticks of zero or one event enter every cycle.
// When the receiver stalls, the output item holds, pending events wait in
// the serializer, and input stall rises once the input register is full.
// Reset clears all keys to released, marks every key as never changed and
// restores the register defaults of 50 ms and a threshold of 100.

module five_key_debouncer import fkd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIN_W-1:0]      i_pin_levels,
    input  logic [LEVEL_W-1:0]    i_ok_level,
    input  logic [TIME_W-1:0]     i_now_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [KEY_IDX_W-1:0]  o_key_index,
    output logic                  o_pressed,
    output logic                  o_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg w_cfg;
    t_evt w_evt;
    logic w_emit_ready;

    fkd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fkd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pin_levels (i_pin_levels),
        .i_ok_level   (i_ok_level),
        .i_now_ms     (i_now_ms),
        .i_emit_ready (w_emit_ready),
        .o_evt        (w_evt)
    );

    fkd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (w_evt),
        .o_ready     (w_emit_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_key_index (o_key_index),
        .o_pressed   (o_pressed),
        .o_last      (o_last)
    );

endmodule
